### sv/dual_stack_shared_memory_core_defines.svh
// Assertion macros shared by the RTL files.
`ifndef DUAL_STACK_SHARED_MEMORY_CORE_DEFINES_SVH
`define DUAL_STACK_SHARED_MEMORY_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DSSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define DSSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/dssm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dssm_pkg;

   localparam int unsigned DEPTH_DEFAULT = 128;
   localparam int unsigned WORD_W        = 32;
   localparam int unsigned STATUS_W      = 2;

   // Pop of an empty stack answers all ones.
   localparam logic [WORD_W-1:0] POP_EMPTY_VALUE = '1;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;
   localparam logic SEL_LOW   = 1'b0;
   localparam logic SEL_HIGH  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACCESS,
      S_RESPOND
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic latch;    // capture request beat
      logic execute;  // do the memory access and pointer update
   } cmd_type;

endpackage

`default_nettype wire

### sv/dssm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "dual_stack_shared_memory_core_defines.svh"

module dssm_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   output logic                 rsp_strobe,
   output dssm_pkg::cmd_type    cmd
);

   dssm_pkg::state_type state_ff, state_in;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dssm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      busy        = 1'b0;
      rsp_strobe  = 1'b0;
      cmd.latch   = 1'b0;
      cmd.execute = 1'b0;
      state_in    = state_ff;
      accept      = 1'b0;
      unique case (state_ff)
         dssm_pkg::S_IDLE: begin
            accept    = start;
            cmd.latch = accept;
            if (accept) state_in = dssm_pkg::S_ACCESS;
         end
         dssm_pkg::S_ACCESS: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
            state_in    = dssm_pkg::S_RESPOND;
         end
         dssm_pkg::S_RESPOND: begin
            // result beat out; next request may come in the same cycle
            rsp_strobe = 1'b1;
            accept     = start;
            cmd.latch  = accept;
            state_in   = accept ? dssm_pkg::S_ACCESS : dssm_pkg::S_IDLE;
         end
         default: begin
            state_in = dssm_pkg::S_IDLE;
         end
      endcase
   end

   `DSSM_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy, "accept without access")
   `DSSM_ASSERT_NOW(a_strobe_after_access, clock, reset, rsp_strobe, $past(state_ff) == dssm_pkg::S_ACCESS, "strobe without access")

endmodule

`default_nettype wire

### sv/dssm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "dual_stack_shared_memory_core_defines.svh"

module dssm_datapath #(
   parameter int unsigned DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire dssm_pkg::cmd_type                  cmd,
   input  wire logic                               req_func,
   input  wire logic                               req_stack_sel,
   input  wire logic signed [dssm_pkg::WORD_W-1:0] req_push_value,
   output logic signed [dssm_pkg::WORD_W-1:0]      rsp_pop_value,
   output logic [dssm_pkg::STATUS_W-1:0]           rsp_status
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [CW:0] DEPTH_SUM = (CW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [dssm_pkg::WORD_W-1:0] mem [DEPTH];

   logic                        func_ff, sel_ff;
   logic [dssm_pkg::WORD_W-1:0] value_ff;
   logic [CW-1:0]               low_count_ff, low_count_in;
   logic [CW-1:0]               high_count_ff, high_count_in;
   dssm_pkg::status_type        status_ff, status_in;
   logic [dssm_pkg::WORD_W-1:0] rd_data_ff;

   logic          full;
   logic [CW:0]   count_sum;
   logic          mem_we, mem_re;
   logic [CW-1:0] addr_wide;
   logic [AW-1:0] addr;

   assign count_sum = {1'b0, low_count_ff} + {1'b0, high_count_ff};
   assign full      = count_sum == DEPTH_SUM;
   assign addr      = addr_wide[AW-1:0];

   always_comb begin
      low_count_in  = low_count_ff;
      high_count_in = high_count_ff;
      status_in     = dssm_pkg::ST_OK;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      addr_wide     = low_count_ff;
      if (func_ff == dssm_pkg::FUNC_PUSH) begin
         if (full) begin
            status_in = dssm_pkg::ST_OVERFLOW;
         end else if (sel_ff == dssm_pkg::SEL_LOW) begin
            mem_we       = cmd.execute;
            addr_wide    = low_count_ff;
            low_count_in = low_count_ff + 1'b1;
         end else begin
            mem_we        = cmd.execute;
            addr_wide     = DEPTH_C - 1'b1 - high_count_ff;
            high_count_in = high_count_ff + 1'b1;
         end
      end else if (sel_ff == dssm_pkg::SEL_LOW) begin
         if (low_count_ff == '0) begin
            status_in = dssm_pkg::ST_EMPTY;
         end else begin
            mem_re       = cmd.execute;
            addr_wide    = low_count_ff - 1'b1;
            low_count_in = low_count_ff - 1'b1;
         end
      end else begin
         if (high_count_ff == '0) begin
            status_in = dssm_pkg::ST_EMPTY;
         end else begin
            mem_re        = cmd.execute;
            addr_wide     = DEPTH_C - high_count_ff;
            high_count_in = high_count_ff - 1'b1;
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff  <= req_func;
         sel_ff   <= req_stack_sel;
         value_ff <= req_push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_count_ff  <= '0;
         high_count_ff <= '0;
      end else if (cmd.execute) begin
         low_count_ff  <= low_count_in;
         high_count_ff <= high_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) status_ff <= status_in;
   end

   // single-port word store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[addr] <= value_ff;
      if (mem_re) rd_data_ff <= mem[addr];
   end

   always_comb begin
      unique case (status_ff)
         dssm_pkg::ST_OK:
            rsp_pop_value = (func_ff == dssm_pkg::FUNC_POP) ? rd_data_ff : '0;
         dssm_pkg::ST_EMPTY:
            rsp_pop_value = dssm_pkg::POP_EMPTY_VALUE;
         default:
            rsp_pop_value = '0;
      endcase
   end

   assign rsp_status = status_ff;

   `DSSM_ASSERT_NOW(a_counts_fit, clock, reset, 1'b1, count_sum <= DEPTH_SUM,
                    "stack counts exceed depth")
   `DSSM_ASSERT_NEXT(a_overflow_holds, clock, reset,
                     cmd.execute && (status_in == dssm_pkg::ST_OVERFLOW),
                     $stable(low_count_ff) && $stable(high_count_ff),
                     "dropped push moved a pointer")

endmodule

`default_nettype wire

### sv/dual_stack_shared_memory_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Two LIFO stacks in one DEPTH-word array: the low stack grows up from
// entry 0, the high stack grows down from entry DEPTH-1. A request beat
// (push or pop, low or high) is taken when start is high and busy is low.
// Each request gives exactly one result beat, shown for one cycle with
// rsp_strobe high; the receiver cannot stall it and must take it then.
// Timing: a taken request is captured, then the array is accessed (the
// read is registered), then the result beat is shown. A new request is
// taken during the result beat; none is taken while the array access is
// in progress, so requests do not overlap. No clearing pass after reset:
// the array needs no initial value.
// Status: 0 ok, 1 push dropped (array full), 2 pop of an empty stack
// (pop value all ones). Pushes return a pop value of zero.

module dual_stack_shared_memory_core #(
   parameter int unsigned DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_func,
   input  wire logic                               req_stack_sel,
   input  wire logic signed [dssm_pkg::WORD_W-1:0] req_push_value,
   // result channel
   output logic                                    rsp_strobe,
   output logic signed [dssm_pkg::WORD_W-1:0]      rsp_pop_value,
   output logic [dssm_pkg::STATUS_W-1:0]           rsp_status
);

   dssm_pkg::cmd_type cmd;

   // sequencer: idle / access / respond
   dssm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // array, stack pointers, result forming
   dssm_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_func),
      .req_stack_sel  (req_stack_sel),
      .req_push_value (req_push_value),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

   // Two stacks sharing one word array.
   //
   // A driver block at the falling edge offers request beats from a queue. An
   // initial block fills that queue before the run starts. A monitor block at
   // the rising edge does two things at the same edge:
   //   - it checks every result beat against the oldest expected result;
   //   - it runs the stack predictor on every request beat the core takes
   //     (start high, busy low).
   // Result beats are checked before the request beat of the same edge is
   // predicted. That way a result is only matched against requests taken at
   // earlier edges.

   localparam int unsigned DEPTH = dssm_pkg::DEPTH_DEFAULT;

   // one request beat as queued for the driver
   typedef struct {
      logic                        func;
      logic                        sel;
      logic [dssm_pkg::WORD_W-1:0] value;
      int unsigned                 idle_pct;    // chance the sender idles before this beat
      bit                          drain_wait;  // marker: hold off until no result is pending
   } stack_req_type;

   typedef struct {
      logic [dssm_pkg::WORD_W-1:0] pop_value;
      dssm_pkg::status_type        status;
   } stack_result_type;

   logic                               clock;
   logic                               reset          = 1'b1;
   logic                               start          = 1'b0;
   logic                               req_func       = dssm_pkg::FUNC_PUSH;
   logic                               req_stack_sel  = dssm_pkg::SEL_LOW;
   logic signed [dssm_pkg::WORD_W-1:0] req_push_value = '0;
   logic                               busy;
   logic                               rsp_strobe;
   logic signed [dssm_pkg::WORD_W-1:0] rsp_pop_value;
   logic [dssm_pkg::STATUS_W-1:0]      rsp_status;

   stack_req_type    req_queue[$];
   stack_result_type expected_results[$];
   int unsigned      error_count = 0;
   bit               beat_taken  = 1'b0;

   // predictor state: a copy of the array and both stack depths
   logic [dssm_pkg::WORD_W-1:0] mirror_words[DEPTH];
   int unsigned                 low_depth  = 0;
   int unsigned                 high_depth = 0;

   // stimulus-side view of the depths, used only to shape the sequences
   int unsigned       plan_low  = 0;
   int unsigned       plan_high = 0;

   dual_stack_shared_memory_core #(
      .DEPTH(DEPTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_stack_sel (req_stack_sel),
      .req_push_value(req_push_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_pop_value (rsp_pop_value),
      .rsp_status    (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Work out the result of one stack operation and apply it to the copy.
   // The low stack fills upward from entry 0. The high stack fills downward
   // from the top entry.
   function automatic stack_result_type apply_stack_op(logic func, logic sel,
                                                       logic [dssm_pkg::WORD_W-1:0] value);
      stack_result_type r;
      r.pop_value = '0;
      r.status    = dssm_pkg::ST_OK;
      if (func == dssm_pkg::FUNC_PUSH) begin
         if (low_depth + high_depth < DEPTH) begin
            if (sel == dssm_pkg::SEL_LOW) begin
               mirror_words[low_depth] = value;
               low_depth++;
            end else begin
               mirror_words[DEPTH - 1 - high_depth] = value;
               high_depth++;
            end
         end else begin
            r.status = dssm_pkg::ST_OVERFLOW;   // array full: push dropped, nothing changes
         end
      end else if (sel == dssm_pkg::SEL_LOW) begin
         if (low_depth > 0) begin
            low_depth--;
            r.pop_value = mirror_words[low_depth];
         end else begin
            r.pop_value = dssm_pkg::POP_EMPTY_VALUE;
            r.status    = dssm_pkg::ST_EMPTY;
         end
      end else begin
         if (high_depth > 0) begin
            r.pop_value = mirror_words[DEPTH - high_depth];
            high_depth--;
         end else begin
            r.pop_value = dssm_pkg::POP_EMPTY_VALUE;
            r.status    = dssm_pkg::ST_EMPTY;
         end
      end
      return r;
   endfunction

   // Words biased toward the extremes, otherwise fully random.
   function automatic logic [dssm_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_op(logic func, logic sel, logic [dssm_pkg::WORD_W-1:0] value,
                           int unsigned pct);
      stack_req_type it;
      it.func       = func;
      it.sel        = sel;
      it.value      = value;
      it.idle_pct   = pct;
      it.drain_wait = 1'b0;
      req_queue.push_back(it);
      // track depths so fill and drain runs know when they are done
      if (func == dssm_pkg::FUNC_PUSH) begin
         if (plan_low + plan_high < DEPTH) begin
            if (sel == dssm_pkg::SEL_LOW) plan_low++;
            else plan_high++;
         end
      end else if (sel == dssm_pkg::SEL_LOW) begin
         if (plan_low > 0) plan_low--;
      end else begin
         if (plan_high > 0) plan_high--;
      end
   endtask

   task automatic queue_drain_pause();
      stack_req_type it;
      it.func       = dssm_pkg::FUNC_PUSH;
      it.sel        = dssm_pkg::SEL_LOW;
      it.value      = '0;
      it.idle_pct   = 0;
      it.drain_wait = 1'b1;
      req_queue.push_back(it);
   endtask

   // Build all stimulus up front.
   initial begin : build_stimulus
      int unsigned phase_pct[3];
      int unsigned phase_base;
      int unsigned kind;
      int unsigned push_pct;
      logic        side;
      bit          first_seg;

      phase_pct[0] = 17;
      phase_pct[1] = 73;
      phase_pct[2] = 0;

      // directed: empty pops on both sides, extreme words on both sides,
      // LIFO order on each side, back to empty again
      queue_op(dssm_pkg::FUNC_POP,  dssm_pkg::SEL_LOW,  $urandom, 0);
      queue_op(dssm_pkg::FUNC_POP,  dssm_pkg::SEL_HIGH, $urandom, 0);
      queue_op(dssm_pkg::FUNC_PUSH, dssm_pkg::SEL_LOW,  32'h8000_0000, 0);
      queue_op(dssm_pkg::FUNC_PUSH, dssm_pkg::SEL_LOW,  32'h7fff_ffff, 0);
      queue_op(dssm_pkg::FUNC_PUSH, dssm_pkg::SEL_HIGH, 32'h0000_0000, 0);
      queue_op(dssm_pkg::FUNC_PUSH, dssm_pkg::SEL_HIGH, 32'hffff_ffff, 0);
      queue_op(dssm_pkg::FUNC_PUSH, dssm_pkg::SEL_LOW,  32'h0000_0000, 0);
      queue_op(dssm_pkg::FUNC_PUSH, dssm_pkg::SEL_HIGH, 32'h8000_0000, 0);
      queue_op(dssm_pkg::FUNC_PUSH, dssm_pkg::SEL_HIGH, 32'h7fff_ffff, 0);
      queue_op(dssm_pkg::FUNC_POP,  dssm_pkg::SEL_HIGH, $urandom, 0);
      queue_op(dssm_pkg::FUNC_POP,  dssm_pkg::SEL_HIGH, $urandom, 0);
      queue_op(dssm_pkg::FUNC_POP,  dssm_pkg::SEL_HIGH, $urandom, 0);
      queue_op(dssm_pkg::FUNC_POP,  dssm_pkg::SEL_LOW,  $urandom, 0);
      queue_op(dssm_pkg::FUNC_POP,  dssm_pkg::SEL_LOW,  $urandom, 0);
      queue_op(dssm_pkg::FUNC_POP,  dssm_pkg::SEL_LOW,  $urandom, 0);
      queue_op(dssm_pkg::FUNC_POP,  dssm_pkg::SEL_HIGH, $urandom, 0);
      queue_op(dssm_pkg::FUNC_POP,  dssm_pkg::SEL_LOW,  $urandom, 0);
      queue_op(dssm_pkg::FUNC_PUSH, dssm_pkg::SEL_HIGH, 32'h5a5a_5a5a, 0);
      queue_op(dssm_pkg::FUNC_POP,  dssm_pkg::SEL_HIGH, 32'ha5a5_a5a5, 0);
      queue_op(dssm_pkg::FUNC_PUSH, dssm_pkg::SEL_LOW,  32'ha5a5_a5a5, 0);
      queue_op(dssm_pkg::FUNC_POP,  dssm_pkg::SEL_LOW,  32'h5a5a_5a5a, 0);
      queue_drain_pause();

      // random: three phases with different idle rates, each a chain of fill runs up to full
      // and past it, drain runs down to empty and past it, and mixed traffic
      for (int p = 0; p < 3; p++) begin
         phase_base = req_queue.size();
         first_seg  = 1'b1;
         while (req_queue.size() - phase_base < 400) begin
            kind = first_seg ? 0 : $urandom_range(0, 3);
            first_seg = 1'b0;
            case (kind)
               0: begin
                  while (plan_low + plan_high < DEPTH)
                     queue_op(dssm_pkg::FUNC_PUSH, 1'($urandom_range(0, 1)), pick_word(),
                              phase_pct[p]);
                  repeat ($urandom_range(2, 5))   // overflow pushes
                     queue_op(dssm_pkg::FUNC_PUSH, 1'($urandom_range(0, 1)), pick_word(),
                              phase_pct[p]);
                  if (p == 1) queue_drain_pause();
               end
               1: begin
                  while (plan_low + plan_high > 0) begin
                     side = 1'($urandom_range(0, 1));
                     if (side == dssm_pkg::SEL_LOW && plan_low == 0) side = dssm_pkg::SEL_HIGH;
                     if (side == dssm_pkg::SEL_HIGH && plan_high == 0) side = dssm_pkg::SEL_LOW;
                     queue_op(dssm_pkg::FUNC_POP, side, $urandom, phase_pct[p]);
                  end
                  repeat ($urandom_range(1, 3))   // pops of empty stacks
                     queue_op(dssm_pkg::FUNC_POP, 1'($urandom_range(0, 1)), $urandom,
                              phase_pct[p]);
               end
               default: begin
                  push_pct = 30 + 20 * $urandom_range(0, 2);
                  repeat ($urandom_range(30, 90))
                     queue_op(($urandom_range(0, 99) < push_pct) ? dssm_pkg::FUNC_PUSH
                                                                 : dssm_pkg::FUNC_POP,
                              1'($urandom_range(0, 1)), pick_word(), phase_pct[p]);
               end
            endcase
         end
         queue_drain_pause();
      end
   end

   // Reset held from the start, released at a falling edge.
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Driver: a new beat goes out once the current one was taken.
   // A drain marker holds start low until every expected result is back.
   always @(negedge clock) begin : drive_beats
      stack_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         beat_taken = 1'b0;
         if (req_queue.size() == 0) begin
            start <= 1'b0;
         end else if (req_queue[0].drain_wait) begin
            start <= 1'b0;
            if (expected_results.size() == 0) void'(req_queue.pop_front());
         end else if ($urandom_range(0, 99) < req_queue[0].idle_pct) begin
            start <= 1'b0;
         end else begin
            nxt = req_queue.pop_front();
            start          <= 1'b1;
            req_func       <= nxt.func;
            req_stack_sel  <= nxt.sel;
            req_push_value <= nxt.value;
         end
      end
   end

   // Monitor: check result beats first, then predict the request beat
   // taken at this edge.
   always @(posedge clock) begin : watch_beats
      stack_result_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: result beat with none expected: pop_value %h status %0d",
                        $time, rsp_pop_value, rsp_status);
            end else begin
               want = expected_results.pop_front();
               if (rsp_pop_value !== want.pop_value) begin
                  error_count++;
                  $display("%0t: pop_value expected %h actual %h",
                           $time, want.pop_value, rsp_pop_value);
               end
               if (rsp_status !== want.status) begin
                  error_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
            end
         end
         if (start && !busy) begin
            expected_results.push_back(apply_stack_op(req_func, req_stack_sel,
                                                      req_push_value));
            beat_taken = 1'b1;
         end
      end
   end

   // End of run: wait until all stimulus has been sent and answered, then
   // watch for stray results before finishing.
   initial begin
      @(negedge clock);
      while (reset || req_queue.size() != 0 || start || expected_results.size() != 0)
         @(negedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Watchdog for a hung core: far beyond the length of a good run.
   initial begin
      #2ms;
      $display("tb: done, errors");
      $finish;
   end

endmodule
